// ===== design/lmip_pkg.sv =====
// Package for the labeled maximum intensity projection block.
// Holds default parameters, fixed field widths, register codes and the
// controller types. No dependencies.
package lmip_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_DEPTH_DEF   = 1024;
    localparam int MAX_LABELS_DEF  = 63;
    localparam int CHANNELS_DEF    = 3;

    localparam int SAMPLE_W    = 16;
    localparam int LABEL_IN_W  = 8;
    localparam int DEPTH_OUT_W = 10;
    localparam int SUM_OUT_W   = 18;
    localparam int LABEL_OUT_W = 9;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MASK = 1'b0;

    localparam logic RESULT_PIXEL = 1'b0;
    localparam logic RESULT_LAYER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_PIXEL,
        S_SCAN,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic load_pixel;
        logic read_layer;
        logic load_layer;
        logic next_idx;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic col_end;
        logic out_free;
        logic layers_none;
        logic seen_at_idx;
        logic layer_last;
    } t_status;

endpackage

// ===== design/lmip_if.sv =====
// Stream interfaces for voxels in and projection results out.
// Depends on lmip_pkg for the field widths.
interface lmip_voxel_if
    import lmip_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [SAMPLE_W-1:0]   chan_a;
    logic [SAMPLE_W-1:0]   chan_b;
    logic [SAMPLE_W-1:0]   chan_c;
    logic [LABEL_IN_W-1:0] label_in;
    logic                  column_end;

    modport source (output valid, chan_a, chan_b, chan_c, label_in, column_end,
                    input ready);
    modport sink   (input valid, chan_a, chan_b, chan_c, label_in, column_end,
                    output ready);
endinterface

interface lmip_result_if
    import lmip_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          result_type;
    logic [SAMPLE_W-1:0]           out_a;
    logic [SAMPLE_W-1:0]           out_b;
    logic [SAMPLE_W-1:0]           out_c;
    logic [DEPTH_OUT_W-1:0]        depth_index;
    logic [SUM_OUT_W-1:0]          sum_value;
    logic signed [LABEL_OUT_W-1:0] label_out;
    logic [SAMPLE_W-1:0]           sample_min;
    logic [SAMPLE_W-1:0]           sample_max;
    logic                          run_last;

    modport source (output valid, result_type, out_a, out_b, out_c, depth_index,
                    sum_value, label_out, sample_min, sample_max, run_last,
                    input ready);
    modport sink   (input valid, result_type, out_a, out_b, out_c, depth_index,
                    sum_value, label_out, sample_min, sample_max, run_last,
                    output ready);
endinterface

// ===== design/labeled_max_intensity_projection.sv =====
// Top level of the labeled maximum intensity projection block.
// Holds the configuration register and joins lmip_ctrl and lmip_dp.
// Depends on lmip_pkg, lmip_if, lmip_ram, lmip_ctrl and lmip_dp.
//
//   Channel   Direction  Kind          Transfer when
//   i_voxel   in         valid/ready   valid and ready high at a rising edge
//   o_result  out        valid/ready   valid and ready high at a rising edge
//   APB       in/out     psel/penable  psel, penable, pready high; pwrite high for a write
//
// A voxel is accepted in S_IDLE, which also reads the label table RAM;
// S_UPDATE then updates the column best, the sample extremes and the table entry.
// A column end adds the combined pixel, a scan of the table entries up to the
// last seen label, and one result per seen label.
// Reset is synchronous and needs no clearing pass; the table RAM is gated by
// per-label seen bits. A stalled result holds only the column-end outputs.
module labeled_max_intensity_projection
    import lmip_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
    parameter int MAX_LABELS  = MAX_LABELS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lmip_voxel_if.sink            i_voxel,
    lmip_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic                 r_use_mask;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_cmd                 cmd;
    t_status              status;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_mask <= 1'b0;
        end else if (psel && penable && pwrite && cfg_idx == REG_USE_MASK) begin
            r_use_mask <= pwdata[0];
        end
    end

    assign prdata = (cfg_idx == REG_USE_MASK) ? CFG_DATA_W'(r_use_mask) : '0;

    lmip_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_voxel.valid),
        .i_status  (status),
        .o_in_ready(i_voxel.ready),
        .o_cmd     (cmd)
    );

    lmip_dp #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_LABELS (MAX_LABELS),
        .CHANNELS   (CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_use_mask   (r_use_mask),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_chan_a     (i_voxel.chan_a),
        .i_chan_b     (i_voxel.chan_b),
        .i_chan_c     (i_voxel.chan_c),
        .i_label_in   (i_voxel.label_in),
        .i_column_end (i_voxel.column_end),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_result_type(o_result.result_type),
        .o_out_a      (o_result.out_a),
        .o_out_b      (o_result.out_b),
        .o_out_c      (o_result.out_c),
        .o_depth_index(o_result.depth_index),
        .o_sum_value  (o_result.sum_value),
        .o_label_out  (o_result.label_out),
        .o_sample_min (o_result.sample_min),
        .o_sample_max (o_result.sample_max),
        .o_run_last   (o_result.run_last)
    );
endmodule

// ===== design/lmip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/lmip_ctrl.sv =====
// Controller state machine for the projection block.
// Depends on lmip_pkg for the state, command and status types.
module lmip_ctrl
    import lmip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.col_end ? S_PIXEL : S_IDLE;
            end
            S_PIXEL: begin
                if (i_status.out_free) begin
                    o_cmd.load_pixel = 1'b1;
                    if (i_status.layers_none) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.seen_at_idx) begin
                    o_cmd.read_layer = 1'b1;
                    n_state          = S_LOAD;
                end else begin
                    o_cmd.next_idx = 1'b1;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_layer = 1'b1;
                    if (i_status.layer_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== design/lmip_dp.sv =====
// Datapath: voxel capture, column best, sample extremes, label layer table
// and the result output register. Depends on lmip_pkg and lmip_ram.
module lmip_dp
    import lmip_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
    parameter int MAX_LABELS  = MAX_LABELS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_use_mask,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic [SAMPLE_W-1:0]           i_chan_a,
    input  logic [SAMPLE_W-1:0]           i_chan_b,
    input  logic [SAMPLE_W-1:0]           i_chan_c,
    input  logic [LABEL_IN_W-1:0]         i_label_in,
    input  logic                          i_column_end,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_result_type,
    output logic [SAMPLE_W-1:0]           o_out_a,
    output logic [SAMPLE_W-1:0]           o_out_b,
    output logic [SAMPLE_W-1:0]           o_out_c,
    output logic [DEPTH_OUT_W-1:0]        o_depth_index,
    output logic [SUM_OUT_W-1:0]          o_sum_value,
    output logic signed [LABEL_OUT_W-1:0] o_label_out,
    output logic [SAMPLE_W-1:0]           o_sample_min,
    output logic [SAMPLE_W-1:0]           o_sample_max,
    output logic                          o_run_last
);
    localparam int SB      = SAMPLE_BITS;
    localparam int SUM_W   = SAMPLE_BITS + 2;
    localparam int DEPTH_W = $clog2(MAX_DEPTH);
    localparam int LBL_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CNT_W   = $clog2(MAX_LABELS + 1);
    localparam int MEM_W   = DEPTH_OUT_W + SUM_W;
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH - 1);
    localparam logic signed [LABEL_OUT_W-1:0] NO_LABEL = '1;

    logic [SB-1:0]                 r_a;
    logic [SB-1:0]                 r_b;
    logic [SB-1:0]                 r_c;
    logic [LABEL_IN_W-1:0]         r_label;
    logic                          r_end;

    logic [SUM_W-1:0]              r_best_sum;
    logic [SB-1:0]                 r_best_a;
    logic [SB-1:0]                 r_best_b;
    logic [SB-1:0]                 r_best_c;
    logic [DEPTH_OUT_W-1:0]        r_best_depth;
    logic signed [LABEL_OUT_W-1:0] r_best_label;
    logic [DEPTH_W-1:0]            r_depth_cnt;
    logic [SB-1:0]                 r_low;
    logic [SB-1:0]                 r_high;
    logic [MAX_LABELS-1:0]         r_seen;
    logic [CNT_W-1:0]              r_layer_cnt;
    logic [CNT_W-1:0]              r_emit_cnt;
    logic [LBL_W-1:0]              r_idx;

    logic                          r_out_valid;
    logic                          r_out_type;
    logic [SAMPLE_W-1:0]           r_out_a;
    logic [SAMPLE_W-1:0]           r_out_b;
    logic [SAMPLE_W-1:0]           r_out_c;
    logic [DEPTH_OUT_W-1:0]        r_out_depth;
    logic [SUM_OUT_W-1:0]          r_out_sum;
    logic signed [LABEL_OUT_W-1:0] r_out_label;
    logic [SAMPLE_W-1:0]           r_out_min;
    logic [SAMPLE_W-1:0]           r_out_max;
    logic                          r_out_last;

    logic [SUM_W-1:0]       sum;
    logic [SB-1:0]          n_low;
    logic [SB-1:0]          n_high;
    logic [LBL_W-1:0]       lidx;
    logic                   in_table;
    logic                   layer_wr;
    logic [DEPTH_OUT_W-1:0] depth_now;
    logic                   mem_re;
    logic [LBL_W-1:0]       mem_raddr;
    logic [MEM_W-1:0]       mem_rdata;
    logic [SUM_W-1:0]       rd_sum;
    logic [DEPTH_OUT_W-1:0] rd_depth;
    logic                   layer_last;

    assign sum       = SUM_W'(r_a) + SUM_W'(r_b) + SUM_W'(r_c);
    assign lidx      = r_label[LBL_W-1:0];
    assign in_table  = r_label < LABEL_IN_W'(MAX_LABELS);
    assign depth_now = DEPTH_OUT_W'(r_depth_cnt);
    assign rd_sum    = mem_rdata[SUM_W-1:0];
    assign rd_depth  = mem_rdata[MEM_W-1:SUM_W];
    assign layer_wr  = i_cmd.update && i_use_mask && in_table
                       && (!r_seen[lidx] || sum > rd_sum);
    assign mem_re    = i_cmd.capture || i_cmd.read_layer;
    assign mem_raddr = i_cmd.capture ? i_label_in[LBL_W-1:0] : r_idx;
    assign layer_last = CNT_W'(r_emit_cnt + 1'b1) == r_layer_cnt;

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        if (r_a < n_low) begin
            n_low = r_a;
        end
        if (r_a > n_high) begin
            n_high = r_a;
        end
        if (CHANNELS >= 2) begin
            if (r_b < n_low) begin
                n_low = r_b;
            end
            if (r_b > n_high) begin
                n_high = r_b;
            end
        end
        if (CHANNELS >= 3) begin
            if (r_c < n_low) begin
                n_low = r_c;
            end
            if (r_c > n_high) begin
                n_high = r_c;
            end
        end
    end

    lmip_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_LABELS),
        .ADDR_W(LBL_W)
    ) u_layer_ram (
        .i_clk  (i_clk),
        .i_we   (layer_wr),
        .i_waddr(lidx),
        .i_wdata({depth_now, sum}),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a     <= i_chan_a[SB-1:0];
            r_b     <= (CHANNELS >= 2) ? i_chan_b[SB-1:0] : '0;
            r_c     <= (CHANNELS >= 3) ? i_chan_c[SB-1:0] : '0;
            r_label <= i_label_in;
            r_end   <= i_column_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_sum   <= '0;
            r_best_a     <= '0;
            r_best_b     <= '0;
            r_best_c     <= '0;
            r_best_depth <= '0;
            r_best_label <= NO_LABEL;
            r_depth_cnt  <= '0;
            r_low        <= '1;
            r_high       <= '0;
            r_seen       <= '0;
            r_layer_cnt  <= '0;
            r_emit_cnt   <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_low  <= n_low;
                r_high <= n_high;
                if (sum > r_best_sum) begin
                    r_best_sum   <= sum;
                    r_best_a     <= r_a;
                    r_best_b     <= r_b;
                    r_best_c     <= r_c;
                    r_best_depth <= depth_now;
                    r_best_label <= i_use_mask ? LABEL_OUT_W'(r_label) : NO_LABEL;
                end
                if (layer_wr) begin
                    r_seen[lidx] <= 1'b1;
                    if (!r_seen[lidx]) begin
                        r_layer_cnt <= CNT_W'(r_layer_cnt + 1'b1);
                    end
                end
                if (r_depth_cnt != DEPTH_TOP) begin
                    r_depth_cnt <= DEPTH_W'(r_depth_cnt + 1'b1);
                end
            end
            if (i_cmd.load_pixel) begin
                r_idx      <= '0;
                r_emit_cnt <= '0;
            end
            if (i_cmd.next_idx) begin
                r_idx <= LBL_W'(r_idx + 1'b1);
            end
            if (i_cmd.load_layer) begin
                r_emit_cnt <= CNT_W'(r_emit_cnt + 1'b1);
            end
            if (i_cmd.clear) begin
                r_best_sum   <= '0;
                r_best_a     <= '0;
                r_best_b     <= '0;
                r_best_c     <= '0;
                r_best_depth <= '0;
                r_best_label <= NO_LABEL;
                r_depth_cnt  <= '0;
                r_seen       <= '0;
                r_layer_cnt  <= '0;
            end
            if (i_cmd.load_pixel || i_cmd.load_layer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_out_type  <= RESULT_PIXEL;
            r_out_a     <= SAMPLE_W'(r_best_a);
            r_out_b     <= SAMPLE_W'(r_best_b);
            r_out_c     <= SAMPLE_W'(r_best_c);
            r_out_depth <= r_best_depth;
            r_out_sum   <= SUM_OUT_W'(r_best_sum);
            r_out_label <= r_best_label;
            r_out_min   <= SAMPLE_W'(r_low);
            r_out_max   <= SAMPLE_W'(r_high);
            r_out_last  <= r_layer_cnt == '0;
        end else if (i_cmd.load_layer) begin
            r_out_type  <= RESULT_LAYER;
            r_out_a     <= '0;
            r_out_b     <= '0;
            r_out_c     <= '0;
            r_out_depth <= rd_depth;
            r_out_sum   <= SUM_OUT_W'(rd_sum);
            r_out_label <= LABEL_OUT_W'(r_idx);
            r_out_min   <= SAMPLE_W'(r_low);
            r_out_max   <= SAMPLE_W'(r_high);
            r_out_last  <= layer_last;
        end
    end

    assign o_status.col_end     = r_end;
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.layers_none = r_layer_cnt == '0;
    assign o_status.seen_at_idx = r_seen[r_idx];
    assign o_status.layer_last  = layer_last;

    assign o_out_valid   = r_out_valid;
    assign o_result_type = r_out_type;
    assign o_out_a       = r_out_a;
    assign o_out_b       = r_out_b;
    assign o_out_c       = r_out_c;
    assign o_depth_index = r_out_depth;
    assign o_sum_value   = r_out_sum;
    assign o_label_out   = r_out_label;
    assign o_sample_min  = r_out_min;
    assign o_sample_max  = r_out_max;
    assign o_run_last    = r_out_last;
endmodule
